// ===== rtl/cdt_gts_pkg.sv =====
// Package with the sampler's widths, table sizes and threshold ROM contents.
`default_nettype none

package cdt_gts_pkg;

  // Field widths.
  localparam int LIMB_W   = 24;
  localparam int CAND_W   = 3 * LIMB_W;
  localparam int SAMPLE_W = 5;

  // Table geometry: rows compared and rows actually stored.
  localparam int TABLE_ROWS  = 19;
  localparam int ROM_ROWS    = 19;
  localparam int ACTIVE_ROWS = (TABLE_ROWS < ROM_ROWS) ? TABLE_ROWS : ROM_ROWS;

  // Table select codes.
  typedef enum logic {
    TBL_ORIGINAL = 1'b0,
    TBL_EXACT    = 1'b1
  } tbl_sel_t;

  typedef logic [CAND_W-1:0] thresh_t;

  // Original reverse-tail thresholds, most significant limb first.
  localparam thresh_t ROM_ORIGINAL [ROM_ROWS] = '{
    {24'd10745844, 24'd3068844,  24'd3741698},
    {24'd5559083,  24'd1580863,  24'd8248194},
    {24'd2260429,  24'd13669192, 24'd2736639},
    {24'd708981,   24'd4421575,  24'd10046180},
    {24'd169348,   24'd7122675,  24'd4136815},
    {24'd30538,    24'd13063405, 24'd7650655},
    {24'd4132,     24'd14505003, 24'd7826148},
    {24'd417,      24'd16768101, 24'd11363290},
    {24'd31,       24'd8444042,  24'd8086568},
    {24'd1,        24'd12844466, 24'd265321},
    {24'd0,        24'd1232676,  24'd13644283},
    {24'd0,        24'd38047,    24'd9111839},
    {24'd0,        24'd870,      24'd6138264},
    {24'd0,        24'd14,       24'd12545723},
    {24'd0,        24'd0,        24'd3104126},
    {24'd0,        24'd0,        24'd28824},
    {24'd0,        24'd0,        24'd198},
    {24'd0,        24'd0,        24'd1},
    {24'd0,        24'd0,        24'd0}
  };

  // Alternative exact-tail thresholds, most significant limb first.
  localparam thresh_t ROM_EXACT [ROM_ROWS] = '{
    {24'd10685138, 24'd6094140,  24'd7629470},
    {24'd5527678,  24'd8670096,  24'd14258550},
    {24'd2247660,  24'd1865395,  24'd13975599},
    {24'd704976,   24'd1013644,  24'd5723061},
    {24'd168391,   24'd12334147, 24'd15547454},
    {24'd30366,    24'd4325902,  24'd15083834},
    {24'd4109,     24'd8674399,  24'd7074295},
    {24'd415,      24'd10705185, 24'd8982890},
    {24'd31,       24'd5458207,  24'd9679761},
    {24'd1,        24'd12677126, 24'd1949237},
    {24'd0,        24'd1225713,  24'd2179374},
    {24'd0,        24'd37832,    24'd10125434},
    {24'd0,        24'd865,      24'd7532402},
    {24'd0,        24'd14,       24'd11147952},
    {24'd0,        24'd0,        24'd3086591},
    {24'd0,        24'd0,        24'd28662},
    {24'd0,        24'd0,        24'd197},
    {24'd0,        24'd0,        24'd1},
    {24'd0,        24'd0,        24'd0}
  };

endpackage

`default_nettype wire

// ===== rtl/cdt_gts_cmp.sv =====
// Bank of constant threshold comparators and the count of rows above the candidate.
`default_nettype none

module cdt_gts_cmp (
  input  wire logic [cdt_gts_pkg::CAND_W-1:0]   candidate,
  input  wire cdt_gts_pkg::tbl_sel_t            table_sel,
  output logic      [cdt_gts_pkg::SAMPLE_W-1:0] sample
);

  logic [cdt_gts_pkg::ACTIVE_ROWS-1:0] hit;

  // One unsigned compare per stored row; rows past the ROM count as zero and never hit.
  always_comb begin
    for (int u = 0; u < cdt_gts_pkg::ACTIVE_ROWS; u++) begin
      if (table_sel == cdt_gts_pkg::TBL_EXACT) begin
        hit[u] = candidate < cdt_gts_pkg::ROM_EXACT[u];
      end else begin
        hit[u] = candidate < cdt_gts_pkg::ROM_ORIGINAL[u];
      end
    end
  end

  // The sample is the number of thresholds greater than the candidate.
  assign sample = cdt_gts_pkg::SAMPLE_W'($countones(hit));

endmodule

`default_nettype wire

// ===== rtl/cdt_gaussian_tail_sampler_core.sv =====
// Top level of the CDT Gaussian base sampler: input register, comparator bank, result register.
`default_nettype none

// The sampler takes one 72-bit uniform candidate per transaction, as three 24-bit limbs, and
// returns the number of rows of the selected threshold table that lie strictly above it.
// Every row is compared on every transaction, so timing does not depend on the data. A new
// transaction is accepted every cycle while the pipeline is not stalled by back-pressure; the
// candidate is held in the input register, and its sample then waits in the result register
// until it is taken. Between those two registers lie the bank of 72-bit constant comparators
// and the population count. Back-pressure on the result side stalls the pipeline without
// losing data.
// cfg_wr_data selects the table when cfg_wr_en is high: 0 for the original thresholds, 1 for
// the exact-tail thresholds; reset selects the original table. Change it only while idle.
module cdt_gaussian_tail_sampler_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration port.
  input  wire logic                                 cfg_wr_en,
  input  wire logic                                 cfg_wr_data,
  // Input channel.
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [cdt_gts_pkg::LIMB_W-1:0]       in_candidate_low,
  input  wire logic [cdt_gts_pkg::LIMB_W-1:0]       in_candidate_mid,
  input  wire logic [cdt_gts_pkg::LIMB_W-1:0]       in_candidate_high,
  // Result channel.
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [cdt_gts_pkg::SAMPLE_W-1:0]     out_sample
);

  cdt_gts_pkg::tbl_sel_t table_sel_r;

  logic                               cand_valid_r;
  logic [cdt_gts_pkg::CAND_W-1:0]     cand_r;
  logic                               out_valid_r;
  logic [cdt_gts_pkg::SAMPLE_W-1:0]   out_sample_r;
  logic [cdt_gts_pkg::SAMPLE_W-1:0]   sample_nxt;
  logic                               advance;

  // Table select register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_sel_r <= cdt_gts_pkg::TBL_ORIGINAL;
    end else if (cfg_wr_en) begin
      table_sel_r <= cdt_gts_pkg::tbl_sel_t'(cfg_wr_data);
    end
  end

  // The input stage moves forward whenever the result register is free or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !cand_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_valid_r <= 1'b0;
    end else if (in_ready) begin
      cand_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cand_r <= {in_candidate_high, in_candidate_mid, in_candidate_low};
    end
  end

  // Comparator bank.
  cdt_gts_cmp u_cmp (
    .candidate (cand_r),
    .table_sel (table_sel_r),
    .sample    (sample_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= cand_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cand_valid_r) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the CDT Gaussian tail sampler core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int THRESH_ROWS = 19;
  localparam int DRAIN_SLACK = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Threshold tables, most significant limb first.
  localparam logic [71:0] ORIG_THRESH [THRESH_ROWS] = '{
    {24'd10745844, 24'd3068844,  24'd3741698},
    {24'd5559083,  24'd1580863,  24'd8248194},
    {24'd2260429,  24'd13669192, 24'd2736639},
    {24'd708981,   24'd4421575,  24'd10046180},
    {24'd169348,   24'd7122675,  24'd4136815},
    {24'd30538,    24'd13063405, 24'd7650655},
    {24'd4132,     24'd14505003, 24'd7826148},
    {24'd417,      24'd16768101, 24'd11363290},
    {24'd31,       24'd8444042,  24'd8086568},
    {24'd1,        24'd12844466, 24'd265321},
    {24'd0,        24'd1232676,  24'd13644283},
    {24'd0,        24'd38047,    24'd9111839},
    {24'd0,        24'd870,      24'd6138264},
    {24'd0,        24'd14,       24'd12545723},
    {24'd0,        24'd0,        24'd3104126},
    {24'd0,        24'd0,        24'd28824},
    {24'd0,        24'd0,        24'd198},
    {24'd0,        24'd0,        24'd1},
    {24'd0,        24'd0,        24'd0}
  };

  localparam logic [71:0] EXACT_THRESH [THRESH_ROWS] = '{
    {24'd10685138, 24'd6094140,  24'd7629470},
    {24'd5527678,  24'd8670096,  24'd14258550},
    {24'd2247660,  24'd1865395,  24'd13975599},
    {24'd704976,   24'd1013644,  24'd5723061},
    {24'd168391,   24'd12334147, 24'd15547454},
    {24'd30366,    24'd4325902,  24'd15083834},
    {24'd4109,     24'd8674399,  24'd7074295},
    {24'd415,      24'd10705185, 24'd8982890},
    {24'd31,       24'd5458207,  24'd9679761},
    {24'd1,        24'd12677126, 24'd1949237},
    {24'd0,        24'd1225713,  24'd2179374},
    {24'd0,        24'd37832,    24'd10125434},
    {24'd0,        24'd865,      24'd7532402},
    {24'd0,        24'd14,       24'd11147952},
    {24'd0,        24'd0,        24'd3086591},
    {24'd0,        24'd0,        24'd28662},
    {24'd0,        24'd0,        24'd197},
    {24'd0,        24'd0,        24'd1},
    {24'd0,        24'd0,        24'd0}
  };

  // Ways of drawing a random candidate.
  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_NEAR_ROW,
    SHAPE_SCALED
  } cand_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [cdt_gts_pkg::LIMB_W-1:0] in_candidate_low = '0;
  logic [cdt_gts_pkg::LIMB_W-1:0] in_candidate_mid = '0;
  logic [cdt_gts_pkg::LIMB_W-1:0] in_candidate_high = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [cdt_gts_pkg::SAMPLE_W-1:0] out_sample;

  // Testbench state shared by the stimulus and checking processes.
  cdt_gts_pkg::tbl_sel_t active_table = cdt_gts_pkg::TBL_ORIGINAL;
  logic [cdt_gts_pkg::SAMPLE_W-1:0] expected_samples [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  cdt_gaussian_tail_sampler_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_candidate_low  (in_candidate_low),
    .in_candidate_mid  (in_candidate_mid),
    .in_candidate_high (in_candidate_high),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample        (out_sample)
  );

  always #4 clk = ~clk;

  function automatic logic [71:0] threshold(input cdt_gts_pkg::tbl_sel_t sel,
                                            input int unsigned row);
    return (sel == cdt_gts_pkg::TBL_EXACT) ? EXACT_THRESH[row] : ORIG_THRESH[row];
  endfunction

  // Number of table rows whose threshold lies strictly above the candidate.
  function automatic logic [cdt_gts_pkg::SAMPLE_W-1:0] tail_count(
      input logic [71:0] cand, input cdt_gts_pkg::tbl_sel_t sel);
    int unsigned n;
    n = 0;
    for (int r = 0; r < cdt_gts_pkg::TABLE_ROWS; r++) begin
      if (r < THRESH_ROWS && cand < threshold(sel, r)) begin
        n++;
      end
    end
    return n[cdt_gts_pkg::SAMPLE_W-1:0];
  endfunction

  // Random candidate: uniform, just around a threshold, or shifted down into the deep tail.
  function automatic logic [71:0] random_candidate(input cdt_gts_pkg::tbl_sel_t sel);
    logic [71:0] c;
    cand_shape_t shape;
    shape = cand_shape_t'($urandom_range(SHAPE_SCALED, SHAPE_UNIFORM));
    c = 72'({$urandom, $urandom, $urandom});
    case (shape)
      SHAPE_NEAR_ROW: begin
        c = threshold(sel, $urandom_range(THRESH_ROWS - 1)) + $urandom_range(8) - 72'd4;
      end
      SHAPE_SCALED: begin
        c = c >> $urandom_range(71);
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // Receiver side: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transaction with the oldest expected sample. Outputs are sampled
  // mid-cycle, where they hold the values that the next rising edge accepts.
  always @(negedge clk) begin
    logic [cdt_gts_pkg::SAMPLE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("Unexpected result transaction: sample %0d", out_sample);
        end
      end else begin
        want = expected_samples.pop_front();
        if (out_sample !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Sample mismatch: expected %0d, got %0d", want, out_sample);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Send one candidate; the expected sample is recorded when the transaction is accepted.
  task automatic send_candidate(input logic [71:0] cand);
    int unsigned gap;
    bit accepted;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_candidate_high <= cand[71:48];
    in_candidate_mid <= cand[47:24];
    in_candidate_low <= cand[23:0];
    do begin
      @(negedge clk);
      accepted = in_ready;
      @(posedge clk);
    end while (!accepted);
    expected_samples.push_back(tail_count(cand, active_table));
  endtask

  // Hold off the sender until every expected sample has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Select a threshold table while the pipeline is empty.
  task automatic set_table(input cdt_gts_pkg::tbl_sel_t sel);
    wait_for_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= logic'(sel);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_table = sel;
  endtask

  // Range ends, limb carries and exact row boundaries for the active table.
  task automatic run_edge_candidates();
    send_candidate('0);
    send_candidate('1);
    send_candidate(72'd1);
    send_candidate({24'd0, 24'd0, 24'hFFFFFF});
    send_candidate({24'd0, 24'hFFFFFF, 24'hFFFFFF});
    send_candidate({24'd1, 24'd0, 24'd0});
    send_candidate(threshold(active_table, 0));
    send_candidate(threshold(active_table, 0) - 72'd1);
    send_candidate(threshold(active_table, 8) - 72'd1);
    send_candidate(threshold(active_table, 13));
    send_candidate(threshold(active_table, 14) - 72'd1);
  endtask

  // Directed edges, first on the table selected by reset, then on the exact-tail table.
  task automatic test_extremes();
    run_edge_candidates();
    set_table(cdt_gts_pkg::TBL_EXACT);
    run_edge_candidates();
  endtask

  // Random candidates under one table and one pattern of sender idling and receiver stalls.
  task automatic test_random_traffic(input cdt_gts_pkg::tbl_sel_t sel,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct, input int unsigned count);
    set_table(sel);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_candidate(random_candidate(active_table));
  endtask

  // A burst into a stalling receiver, a full drain with the sender held off, then more.
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_stall_pct = 59;
    repeat (20) send_candidate(random_candidate(active_table));
    wait_for_drain();
    repeat (20) send_candidate(random_candidate(active_table));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_random_traffic(cdt_gts_pkg::TBL_ORIGINAL, 0, 0, 290);
    test_random_traffic(cdt_gts_pkg::TBL_EXACT, 59, 0, 290);
    test_drain_pause();
    test_random_traffic(cdt_gts_pkg::TBL_ORIGINAL, 0, 59, 290);
    test_random_traffic(cdt_gts_pkg::TBL_EXACT, 35, 35, 290);

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cdt_gts_pkg.sv
rtl/cdt_gts_cmp.sv
rtl/cdt_gaussian_tail_sampler_core.sv
tb/tb_top.sv
